### rtl/core/tcf_pkg.sv
package tcf_pkg;

    localparam int ATAN_LEN   = 24;
    localparam int STEP_IDX_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_OFFSET    = 3'd0,
        CFG_GYRO_GAIN      = 3'd1,
        CFG_BLEND_WEIGHT   = 3'd2,
        CFG_RECAPTURE_LOW  = 3'd3,
        CFG_RECAPTURE_HIGH = 3'd4,
        CFG_CRITICAL_LOW   = 3'd5,
        CFG_CRITICAL_HIGH  = 3'd6
    } tcf_cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] gyro_offset;
        logic        [15:0] gyro_gain;
        logic        [15:0] blend_weight;
        logic signed [16:0] recapture_low;
        logic signed [16:0] recapture_high;
        logic signed [16:0] critical_low;
        logic signed [16:0] critical_high;
    } tcf_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_GAIN,
        ST_SUM,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_FINISH
    } tcf_state_t;

    typedef struct packed {
        logic                  load;
        logic                  rotate;
        logic                  gain;
        logic                  sum;
        logic                  blend_a;
        logic                  blend_b;
        logic                  finish;
        logic [STEP_IDX_W-1:0] step;
    } tcf_cmd_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [21:0] atan_q16(input logic [STEP_IDX_W-1:0] idx);
        logic [21:0] v;
        begin
            unique case (idx)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

### rtl/core/tcf_regs.sv
module tcf_regs
    import tcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output tcf_cfg_t              cfg
);

    tcf_cfg_t cfg_reg;
    tcf_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GYRO_OFFSET:    cfg_next.gyro_offset    = $signed(cfg_data[15:0]);
                CFG_GYRO_GAIN:      cfg_next.gyro_gain      = cfg_data[15:0];
                CFG_BLEND_WEIGHT:   cfg_next.blend_weight   = cfg_data[15:0];
                CFG_RECAPTURE_LOW:  cfg_next.recapture_low  = $signed(cfg_data);
                CFG_RECAPTURE_HIGH: cfg_next.recapture_high = $signed(cfg_data);
                CFG_CRITICAL_LOW:   cfg_next.critical_low   = $signed(cfg_data);
                CFG_CRITICAL_HIGH:  cfg_next.critical_high  = $signed(cfg_data);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gyro_offset    <= 16'sd0;
            cfg_reg.gyro_gain      <= 16'd1281;
            cfg_reg.blend_weight   <= 16'd262;
            cfg_reg.recapture_low  <= 17'sd17920;
            cfg_reg.recapture_high <= 17'sd30720;
            cfg_reg.critical_low   <= 17'sd16640;
            cfg_reg.critical_high  <= 17'sd32000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/tcf_ctrl.sv
module tcf_ctrl
    import tcf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output tcf_cmd_t cmd
);

    localparam int STEPS_EFF = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int STEP_W    = $clog2(STEPS_EFF);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_EFF - 1);

    tcf_state_t        state_reg;
    tcf_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    // output word register can take a new word this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_ROTATE;
            ST_ROTATE:  if (step_reg == LAST_STEP) state_next = ST_GAIN;
            ST_GAIN:    state_next = ST_SUM;
            ST_SUM:     state_next = ST_BLEND_A;
            ST_BLEND_A: state_next = ST_BLEND_B;
            ST_BLEND_B: state_next = ST_FINISH;
            ST_FINISH:  if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.step       = STEP_IDX_W'(step_reg);
        in_stall       = 1'b1;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                step_next = '0;
                cmd.load  = in_valid;
            end
            ST_ROTATE:
            begin
                cmd.rotate = 1'b1;
                step_next  = step_reg + 1'b1;
            end
            ST_GAIN:    cmd.gain    = 1'b1;
            ST_SUM:     cmd.sum     = 1'b1;
            ST_BLEND_A: cmd.blend_a = 1'b1;
            ST_BLEND_B: cmd.blend_b = 1'b1;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:    in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/tcf_datapath.sv
module tcf_datapath
    import tcf_pkg::*;
#(
    parameter int ANGLE_FRACTION_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tcf_cmd_t           cmd,
    input  tcf_cfg_t           cfg,
    input  logic signed [15:0] accel_x_raw,
    input  logic signed [15:0] accel_z_raw,
    input  logic signed [15:0] gyro_y_raw,
    output logic signed [16:0] accel_deg,
    output logic signed [17:0] filtered_angle,
    output logic               tilt_critical,
    output logic signed [16:0] rate_corrected
);

    localparam int RND_SHIFT = 16 - ANGLE_FRACTION_BITS;
    localparam logic signed [25:0] Z_HALF  = 26'(1 << (15 - ANGLE_FRACTION_BITS));
    localparam logic signed [25:0] ACC_LIM = 26'(180 << ANGLE_FRACTION_BITS);
    localparam logic signed [21:0] EST_LIM = 22'(360 << ANGLE_FRACTION_BITS);
    localparam logic signed [25:0] Z_QUARTER = 26'sd5898240;   // 90 degrees

    // CORDIC vector and angle accumulator
    logic signed [35:0] x_reg, x_next;
    logic signed [35:0] y_reg, y_next;
    logic signed [25:0] z_reg, z_next;
    logic               zero_reg;

    logic signed [16:0] rate_reg;
    logic signed [16:0] acc_reg;
    logic signed [33:0] prod_g_reg;
    logic signed [18:0] est_sum_reg;
    logic signed [36:0] prod_a_reg;
    logic signed [33:0] prod_b_reg;

    logic signed [17:0] est_reg;
    logic               crit_reg;

    logic signed [16:0] accel_deg_reg;
    logic signed [17:0] filtered_angle_reg;
    logic               tilt_critical_reg;
    logic signed [16:0] rate_corrected_reg;

    logic signed [35:0] x0, y0;
    logic signed [35:0] dx, dy;
    logic signed [25:0] atan_ext;
    logic signed [25:0] z_rnd, z_sat;
    logic signed [16:0] acc_next;
    logic signed [17:0] est_sel;
    logic signed [34:0] g_round;
    logic signed [18:0] g_term;
    logic signed [17:0] w_comp;
    logic signed [16:0] w_s;
    logic signed [37:0] b_sum;
    logic signed [21:0] b_q, b_sat;
    logic signed [17:0] est_new;
    logic               crit_new;
    logic               recapture;

    always_comb
    begin
        x0 = -$signed({{4{accel_z_raw[15]}}, accel_z_raw, 16'h0000});
        y0 = $signed({{4{accel_x_raw[15]}}, accel_x_raw, 16'h0000});
        dx = y_reg >>> cmd.step;
        dy = x_reg >>> cmd.step;
        atan_ext = $signed({4'b0000, atan_q16(cmd.step)});
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (cmd.load)
        begin
            // start in the right half plane
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    x_next = y0;
                    y_next = -x0;
                    z_next = Z_QUARTER;
                end
                else
                begin
                    x_next = -y0;
                    y_next = x0;
                    z_next = -Z_QUARTER;
                end
            end
            else
            begin
                x_next = x0;
                y_next = y0;
                z_next = '0;
            end
        end
        else if (cmd.rotate)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_ext;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_ext;
            end
        end
    end

    // round z to angle units, limit to +-180 degrees and to 17 bits
    always_comb
    begin
        z_rnd = (z_reg + Z_HALF) >>> RND_SHIFT;
        z_sat = z_rnd;
        if (z_sat > ACC_LIM)
            z_sat = ACC_LIM;
        else if (z_sat < -ACC_LIM)
            z_sat = -ACC_LIM;
        if (z_sat > 26'sd65535)
            acc_next = 17'sd65535;
        else if (z_sat < -26'sd65536)
            acc_next = -17'sd65536;
        else
            acc_next = z_sat[16:0];
        if (zero_reg)
            acc_next = '0;
    end

    always_comb
    begin
        recapture = crit_reg && (acc_reg > cfg.recapture_low) && (acc_reg < cfg.recapture_high);
        est_sel   = recapture ? 18'(acc_reg) : est_reg;
        g_round   = 35'(prod_g_reg) + 35'sd32768;
        g_term    = g_round[34:16];
        w_s       = $signed({1'b0, cfg.blend_weight});
        w_comp    = 18'sd65536 - 18'(w_s);
        b_sum     = 38'(prod_a_reg) + 38'(prod_b_reg) + 38'sd32768;
        b_q       = b_sum[37:16];
        b_sat     = b_q;
        if (b_sat > EST_LIM)
            b_sat = EST_LIM;
        else if (b_sat < -EST_LIM)
            b_sat = -EST_LIM;
        if (b_sat > 22'sd131071)
            est_new = 18'sd131071;
        else if (b_sat < -22'sd131072)
            est_new = -18'sd131072;
        else
            est_new = b_sat[17:0];
        crit_new = (est_new < 18'(cfg.critical_low)) || (est_new > 18'(cfg.critical_high));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg  <= '0;
            crit_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            est_reg  <= est_new;
            crit_reg <= crit_new;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (cmd.load)
        begin
            zero_reg <= (accel_x_raw == 16'sd0) && (accel_z_raw == 16'sd0);
            rate_reg <= 17'(gyro_y_raw) - 17'(cfg.gyro_offset);
        end
        if (cmd.gain)
        begin
            prod_g_reg <= rate_reg * $signed({1'b0, cfg.gyro_gain});
            acc_reg    <= acc_next;
        end
        if (cmd.sum)
            est_sum_reg <= 19'(est_sel) + g_term;
        if (cmd.blend_a)
            prod_a_reg <= est_sum_reg * w_comp;
        if (cmd.blend_b)
            prod_b_reg <= acc_reg * w_s;
        if (cmd.finish)
        begin
            accel_deg_reg      <= acc_reg;
            filtered_angle_reg <= est_new;
            tilt_critical_reg  <= crit_new;
            rate_corrected_reg <= rate_reg;
        end
    end

    assign accel_deg      = accel_deg_reg;
    assign filtered_angle = filtered_angle_reg;
    assign tilt_critical  = tilt_critical_reg;
    assign rate_corrected = rate_corrected_reg;

endmodule

### rtl/core/tilt_complementary_filter.sv
// Tilt complementary filter. Each input word (accel X, accel Z, gyro Y) yields one output
// word: the accelerometer angle atan2(ax, -az), the filtered tilt angle, the critical-tilt
// flag and the bias-corrected gyro rate; angles are in 2^-ANGLE_FRACTION_BITS degree. The
// input is taken only when the block is idle. Each word is loaded, runs its CORDIC
// iterations one after another on the single shift-add unit, then goes through the gain
// multiply, the sum, the two blend multiplies and the final clamp. The finished word sits
// in an output register, so the next input is accepted while it waits; a stalled output
// holds the block only at its final step. Registers must be written by the user through
// cfg_we/cfg_index/cfg_data only while idle; the block itself does not enforce this.
// Indexes beyond the last register are ignored.
module tilt_complementary_filter
    import tcf_pkg::*;
#(
    parameter int CORDIC_STEPS        = 16,
    parameter int ANGLE_FRACTION_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [15:0]    accel_x_raw,
    input  logic signed [15:0]    accel_z_raw,
    input  logic signed [15:0]    gyro_y_raw,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [16:0]    accel_deg,
    output logic signed [17:0]    filtered_angle,
    output logic                  tilt_critical,
    output logic signed [16:0]    rate_corrected
);

    tcf_cfg_t cfg;
    tcf_cmd_t cmd;

    tcf_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tcf_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tcf_datapath #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg),
        .accel_x_raw    (accel_x_raw),
        .accel_z_raw    (accel_z_raw),
        .gyro_y_raw     (gyro_y_raw),
        .accel_deg      (accel_deg),
        .filtered_angle (filtered_angle),
        .tilt_critical  (tilt_critical),
        .rate_corrected (rate_corrected)
    );

endmodule

### tb/tilt_complementary_filter_tb.sv
module tilt_complementary_filter_tb;
    import tcf_pkg::*;

    localparam int TILT_STEPS  = 16;
    localparam int TILT_FRAC   = 8;
    localparam int PHASE_WORDS = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int LIMIT       = 400000;

    // no register lives at this index; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic signed [16:0] acc;
        logic signed [17:0] filt;
        logic               crit;
        logic signed [16:0] rate;
    } tilt_word_t;

    typedef struct {
        int ax;
        int az;
        int gy;
        bit typed;
        int e_acc;
        int e_filt;
        bit e_crit;
        int e_rate;
    } tilt_row_t;

    // atan(2^-i), 2^-16 degree
    localparam longint ATAN_TAB [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    localparam int DIR_ROWS = 21;
    tilt_row_t dir_rows [DIR_ROWS] = '{
        '{0, 0, 0, 1, 0, 0, 1, 0},
        '{0, 0, 5, 1, 0, 0, 1, 5},
        '{16384, 0, 0, 0, 0, 0, 0, 0},
        '{0, -16384, 0, 0, 0, 0, 0, 0},
        '{32767, -32768, 32767, 0, 0, 0, 0, 0},
        '{-32768, -32768, -32768, 0, 0, 0, 0, 0},
        '{32767, 32767, 0, 0, 0, 0, 0, 0},
        '{-32768, 32767, 0, 0, 0, 0, 0, 0},
        '{0, 32767, 0, 0, 0, 0, 0, 0},
        '{-1, 32767, 0, 0, 0, 0, 0, 0},
        '{1, 32767, -1, 0, 0, 0, 0, 0},
        '{-32768, 0, 100, 0, 0, 0, 0, 0},
        '{32767, 0, -100, 0, 0, 0, 0, 0},
        '{0, -32768, 32767, 0, 0, 0, 0, 0},
        '{0, 1, 0, 0, 0, 0, 0, 0},
        '{0, -1, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 0, 0, 0, 0, 0},
        '{-1, 0, 0, 0, 0, 0, 0, 0},
        '{16384, 16384, 0, 0, 0, 0, 0, 0},
        '{18000, 0, -32768, 0, 0, 0, 0, 0},
        '{0, 0, 32767, 0, 0, 0, 0, 0}
    };

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic signed [15:0]    accel_x_raw = '0;
    logic signed [15:0]    accel_z_raw = '0;
    logic signed [15:0]    gyro_y_raw  = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic signed [16:0]    accel_deg;
    logic signed [17:0]    filtered_angle;
    logic                  tilt_critical;
    logic signed [16:0]    rate_corrected;

    tcf_cfg_t           tilt_cfg;
    logic signed [17:0] est_angle;
    logic               crit_state;
    tilt_word_t         angle_q [$];

    int idle_pct;
    int stall_pct;
    int hold_req_cnt;
    int hold_done_cnt;
    int bad_cnt;

    tilt_complementary_filter #(
        .CORDIC_STEPS        (TILT_STEPS),
        .ANGLE_FRACTION_BITS (TILT_FRAC)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .accel_x_raw    (accel_x_raw),
        .accel_z_raw    (accel_z_raw),
        .gyro_y_raw     (gyro_y_raw),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accel_deg      (accel_deg),
        .filtered_angle (filtered_angle),
        .tilt_critical  (tilt_critical),
        .rate_corrected (rate_corrected)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // atan2(ax, -az) by vectoring CORDIC, in 2^-TILT_FRAC degree
    function automatic logic signed [16:0] accel_tilt(input logic signed [15:0] ax_s,
                                                      input logic signed [15:0] az_s);
        longint x, y, z, t, dx, dy, lim;
        x = -longint'(az_s) * 65536;
        y = longint'(ax_s) * 65536;
        z = 0;
        lim = longint'(180) <<< TILT_FRAC;
        if (ax_s == 0 && az_s == 0)
            return '0;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end
            else
            begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < TILT_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end
        end
        z = (z + (longint'(1) <<< (15 - TILT_FRAC))) >>> (16 - TILT_FRAC);
        if (z > lim) z = lim;
        if (z < -lim) z = -lim;
        if (z > 65535) z = 65535;
        if (z < -65536) z = -65536;
        return 17'(z);
    endfunction

    function automatic tilt_word_t tilt_predict(input logic signed [15:0] ax,
                                                input logic signed [15:0] az,
                                                input logic signed [15:0] gy);
        tilt_word_t r;
        longint acc, rate, gain, w, est, lim;
        acc  = accel_tilt(ax, az);
        rate = longint'(gy) - longint'($signed(tilt_cfg.gyro_offset));
        gain = longint'(tilt_cfg.gyro_gain);
        w    = longint'(tilt_cfg.blend_weight);
        est  = est_angle;
        lim  = longint'(360) <<< TILT_FRAC;
        // recapture: flag set and accel angle strictly inside the window
        if (crit_state && acc > $signed(tilt_cfg.recapture_low)
                       && acc < $signed(tilt_cfg.recapture_high))
        begin
            crit_state = 1'b0;
            est = acc;
        end
        est = est + ((rate * gain + 32768) >>> 16);
        est = (est * (65536 - w) + acc * w + 32768) >>> 16;
        if (est > lim) est = lim;
        if (est < -lim) est = -lim;
        if (est > 131071) est = 131071;
        if (est < -131072) est = -131072;
        est_angle  = 18'(est);
        crit_state = (est < $signed(tilt_cfg.critical_low)) ||
                     (est > $signed(tilt_cfg.critical_high));
        r.acc  = 17'(acc);
        r.filt = est_angle;
        r.crit = crit_state;
        r.rate = 17'(rate);
        return r;
    endfunction

    function automatic logic [15:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 16'($urandom);
        else if (sel < 8)
            return 16'(int'($urandom_range(0, 128)) - 64);
        else
        begin
            case ($urandom_range(0, 4))
                0:       return 16'h8000;
                1:       return 16'h7fff;
                2:       return 16'hffff;
                3:       return 16'h0001;
                default: return 16'h0000;
            endcase
        end
    endfunction

    // one word on the input channel; expectation is pushed at the accepting edge
    task automatic send_word(input logic [15:0] ax, input logic [15:0] az,
                             input logic [15:0] gy, input bit typed,
                             input tilt_word_t typed_exp);
        tilt_word_t pred;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        accel_x_raw <= ax;
        accel_z_raw <= az;
        gyro_y_raw  <= gy;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = tilt_predict(ax, az, gy);
        angle_q.push_back(typed ? typed_exp : pred);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (angle_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_GYRO_OFFSET:    tilt_cfg.gyro_offset    = val[15:0];
            CFG_GYRO_GAIN:      tilt_cfg.gyro_gain      = val[15:0];
            CFG_BLEND_WEIGHT:   tilt_cfg.blend_weight   = val[15:0];
            CFG_RECAPTURE_LOW:  tilt_cfg.recapture_low  = val;
            CFG_RECAPTURE_HIGH: tilt_cfg.recapture_high = val;
            CFG_CRITICAL_LOW:   tilt_cfg.critical_low   = val;
            CFG_CRITICAL_HIGH:  tilt_cfg.critical_high  = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int off, input int gain, input int w,
                                  input int rl, input int rh, input int cl, input int ch);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        // bit 16 of a 16-bit register is random and must be dropped
        write_reg(CFG_GYRO_OFFSET,    {1'($urandom), 16'(off)});
        write_reg(CFG_GYRO_GAIN,      {1'($urandom), 16'(gain)});
        write_reg(CFG_BLEND_WEIGHT,   {1'($urandom), 16'(w)});
        write_reg(CFG_RECAPTURE_LOW,  17'(rl));
        write_reg(CFG_RECAPTURE_HIGH, 17'(rh));
        write_reg(CFG_CRITICAL_LOW,   17'(cl));
        write_reg(CFG_CRITICAL_HIGH,  17'(ch));
        write_reg(CFG_UNUSED_IDX,     17'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int rand_window();
        return int'($urandom_range(0, 92160)) - 46080;
    endfunction

    // receiver side: random stall plus an occasional long hold
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req_cnt != hold_done_cnt)
            begin
                hold_done_cnt++;
                for (int k = 0; k < HOLD_CYCLES; k++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        tilt_word_t got, exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            got.acc  = accel_deg;
            got.filt = filtered_angle;
            got.crit = tilt_critical;
            got.rate = rate_corrected;
            if (angle_q.size() == 0)
            begin
                bad_cnt++;
                if (bad_cnt <= 10)
                    $display("unexpected word: acc %0d filt %0d crit %0d rate %0d",
                             got.acc, got.filt, got.crit, got.rate);
            end
            else
            begin
                exp_w = angle_q.pop_front();
                if (got.acc !== exp_w.acc || got.filt !== exp_w.filt ||
                    got.crit !== exp_w.crit || got.rate !== exp_w.rate)
                begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display({"mismatch: exp acc %0d filt %0d crit %0d rate %0d,",
                                  " got acc %0d filt %0d crit %0d rate %0d"},
                                 exp_w.acc, exp_w.filt, exp_w.crit, exp_w.rate,
                                 got.acc, got.filt, got.crit, got.rate);
                end
            end
        end
    end

    initial
    begin
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        tilt_word_t typed_exp;
        tilt_cfg.gyro_offset    = 16'sd0;
        tilt_cfg.gyro_gain      = 16'd1281;
        tilt_cfg.blend_weight   = 16'd262;
        tilt_cfg.recapture_low  = 17'sd17920;
        tilt_cfg.recapture_high = 17'sd30720;
        tilt_cfg.critical_low   = 17'sd16640;
        tilt_cfg.critical_high  = 17'sd32000;
        est_angle     = '0;
        crit_state    = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_req_cnt  = 0;
        hold_done_cnt = 0;
        bad_cnt       = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            typed_exp.acc  = 17'(dir_rows[i].e_acc);
            typed_exp.filt = 18'(dir_rows[i].e_filt);
            typed_exp.crit = dir_rows[i].e_crit;
            typed_exp.rate = 17'(dir_rows[i].e_rate);
            send_word(16'(dir_rows[i].ax), 16'(dir_rows[i].az), 16'(dir_rows[i].gy),
                      dir_rows[i].typed, typed_exp);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                1, 5:    apply_settings(int'($urandom_range(0, 65535)) - 32768,
                                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                                        rand_window(), rand_window(),
                                        rand_window(), rand_window());
                2:       apply_settings(-32768, 65535, 0, -46080, 46080, -46080, 46080);
                3:       apply_settings(32767, 65535, 65535, 46080, -46080, 46080, -46080);
                4:       apply_settings(0, 0, 0, 17920, 30720, 16640, 32000);
                6:       apply_settings(0, 1281, 262, 17920, 30720, 16640, 32000);
                7:       apply_settings(int'($urandom_range(0, 512)) - 256,
                                        $urandom_range(0, 4096), $urandom_range(0, 8192),
                                        rand_window(), rand_window(),
                                        rand_window(), rand_window());
                default: ;
            endcase
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 46; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // long output hold while words keep coming: the block must back up
                if ((ph == 2 || ph == 5) && n == 20)
                    hold_req_cnt++;
                if (ph == 6 && n == 100)
                    wait_drained();
                send_word(pick_sample(), pick_sample(), pick_sample(), 1'b0, typed_exp);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (bad_cnt == 0 && angle_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### tilt_complementary_filter.f
rtl/core/tcf_pkg.sv
rtl/core/tcf_regs.sv
rtl/core/tcf_ctrl.sv
rtl/core/tcf_datapath.sv
rtl/core/tilt_complementary_filter.sv
tb/tilt_complementary_filter_tb.sv
